/* rtl/assert_macros.svh */
// Assertion macros used by the ASCII decimal parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AD_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define AD_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define AD_ASSERT_IMP(lbl, clk, rst_n, a, b, msg)
`define AD_ASSERT_NXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

/* rtl/ad2i_pkg.sv */
// Types and constants for the ASCII decimal to int32 parser.
package ad2i_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0]  DIGIT_MASK = 4'hF;
	localparam int          MAG_W      = 31;
	localparam logic [31:0] MIN_NEG    = 32'h8000_0000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_NODIGITS = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} char_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		status_t            status;
	} result_word_t;

endpackage

/* rtl/ad2i_stream_if.sv */
// Valid/ready stream interface carrying one word per handshake.
interface ad2i_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/ascii_decimal_to_int32.sv */
// Top level: ASCII decimal string to signed 32-bit integer parser.
//
//   channel   dir  word            fields
//   chars     in   char_word_t     character[7:0], last
//   results   out  result_word_t   value[31:0] signed, status[1:0]
//
// One character word is taken per cycle unless the input stalls (see below); the result
// for the word marked last goes through the input register, then the result register.
// The multiply-by-ten-and-add, status and sign logic sit between the two registers.
// arst_n clears the parse state and both valid flags.
// Input stalls only while a last word waits in the input register and the
// result register is full and not being taken.
`include "assert_macros.svh"

module ascii_decimal_to_int32
	import ad2i_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	ad2i_stream_if.sink    chars,
	ad2i_stream_if.source  results
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;
	logic             adv_s1;

	logic [MAG_W-1:0] acc_q;
	logic             neg_q;
	logic             digit_q;
	logic             ended_q;
	status_t          err_q;

	logic [MAG_W-1:0] acc_n;
	logic             neg_n;
	logic             digit_n;
	logic             ended_n;
	status_t          err_n;

	logic [MAG_W+3:0] ext;
	logic [MAG_W+3:0] prod;
	logic             ovf;

	status_t          status_n;
	logic [31:0]      mag_n;
	logic [31:0]      value_n;

	logic             res_valid_q;
	result_word_t     res_q;

	assign adv_s1      = valid_s1 && (!last_s1 || !res_valid_q || results.ready);
	assign chars.ready = !valid_s1 || adv_s1;

	assign ext  = {4'b0, acc_q};
	assign prod = (ext << 3) + (ext << 1) + {{MAG_W{1'b0}}, char_s1[3:0] & DIGIT_MASK};
	assign ovf  = |prod[MAG_W+3:MAG_W];

	always_comb begin
		acc_n   = acc_q;
		neg_n   = neg_q;
		digit_n = digit_q;
		ended_n = ended_q;
		err_n   = err_q;
		if (!ended_q && err_q == ST_OK) begin
			case (char_s1) inside
				CH_NUL: begin
					ended_n = 1'b1;
				end
				CH_SPACE: begin
					if (digit_q) ended_n = 1'b1;
				end
				CH_MINUS: begin
					if (digit_q) err_n = ST_INVALID;
					else neg_n = 1'b1;
				end
				CH_PLUS: begin
					if (digit_q || neg_q) err_n = ST_INVALID;
				end
				[CH_ZERO:CH_NINE]: begin
					digit_n = 1'b1;
					if (ovf) err_n = ST_OVERFLOW;
					else acc_n = prod[MAG_W-1:0];
				end
				default: begin
					err_n = ST_INVALID;
				end
			endcase
		end
	end

	always_comb begin
		if (err_n != ST_OK) status_n = err_n;
		else if (!digit_n) status_n = ST_NODIGITS;
		else status_n = ST_OK;
		mag_n = {1'b0, acc_n};
		if (status_n != ST_OK) value_n = '0;
		else if (neg_n) value_n = 32'd0 - mag_n;
		else value_n = mag_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.data.character;
			last_s1 <= chars.data.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			digit_q <= 1'b0;
			ended_q <= 1'b0;
			err_q   <= ST_OK;
		end else if (adv_s1) begin
			if (last_s1) begin
				acc_q   <= '0;
				neg_q   <= 1'b0;
				digit_q <= 1'b0;
				ended_q <= 1'b0;
				err_q   <= ST_OK;
			end else begin
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				digit_q <= digit_n;
				ended_q <= ended_n;
				err_q   <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_q.value  <= value_n;
			res_q.status <= status_n;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	`AD_ASSERT_IMP(a_ok_in_range, clk, arst_n, res_valid_q && res_q.status == ST_OK, res_q.value != MIN_NEG, "ok result outside int32 magnitude range")
	`AD_ASSERT_IMP(a_err_zero, clk, arst_n, res_valid_q && res_q.status != ST_OK, res_q.value == 32'sd0, "non-ok result carries a nonzero value")
	`AD_ASSERT_NXT(a_clear_after_last, clk, arst_n, adv_s1 && last_s1, acc_q == '0 && !digit_q && !neg_q && !ended_q && err_q == ST_OK, "parse state not cleared after last word")
	`AD_ASSERT_IMP(a_acc_needs_digit, clk, arst_n, !digit_q, acc_q == '0, "accumulator nonzero before any digit")

endmodule
